FILE: sv/mrsa_pkg.sv
// ----------------------------------------------------------------------------
// mrsa_pkg: shared types and constants for the meter reading averager
// Word formats, scaling band constants and the per-band reciprocals.
// ----------------------------------------------------------------------------
package mrsa_pkg;

	localparam int MODE_W      = 2;
	localparam int READING_W   = 24;
	localparam int X_W         = 25;   // dividend, holds the negated power up to 2^24
	localparam int DIV_W       = 16;
	localparam int RECIP_SHIFT = 25;
	localparam int RECIP_W     = 20;
	localparam int SCALED_W    = 19;
	localparam int AVG_W       = 19;
	localparam int SCALED_MAX  = 279550;
	localparam int DEFAULT_SAMPLES = 10;

	localparam logic [MODE_W-1:0] MODE_VOLTAGE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CURRENT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_POWER   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

	// band edges
	localparam logic [READING_W-1:0] VOLT_KNEE = 24'd6000000;
	localparam logic [READING_W-1:0] CUR_KNEE1 = 24'd270000;
	localparam logic [READING_W-1:0] CUR_KNEE2 = 24'd290000;
	localparam logic [READING_W-1:0] CUR_KNEE3 = 24'd330000;
	localparam logic [READING_W-1:0] CUR_KNEE4 = 24'd360000;
	localparam logic [X_W-1:0]       POWER_KNEE   = 25'd6000;
	localparam logic [SCALED_W-1:0]  POWER_OFFSET = 19'd30;

	// effective divisors once the scale factor is folded in
	localparam logic [DIV_W-1:0] DIV_VOLT_LO = 16'd40000; // 6000000 / 150
	localparam logic [DIV_W-1:0] DIV_VOLT_HI = 16'd38000; // 7600000 / 200
	localparam logic [DIV_W-1:0] DIV_CUR_1   = 16'd3000;
	localparam logic [DIV_W-1:0] DIV_CUR_2   = 16'd1500;
	localparam logic [DIV_W-1:0] DIV_CUR_3   = 16'd1100;
	localparam logic [DIV_W-1:0] DIV_CUR_4   = 16'd950;
	localparam logic [DIV_W-1:0] DIV_CUR_5   = 16'd860;
	localparam logic [DIV_W-1:0] DIV_POW_LO  = 16'd470;  // 47000 / 100
	localparam logic [DIV_W-1:0] DIV_POW_HI  = 16'd60;   // 60000 / 1000

	// floor(2^25 / d): quotient estimate is low by at most one
	localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_VOLT_LO = RECIP_W'(RECIP_ONE / 64'(DIV_VOLT_LO));
	localparam logic [RECIP_W-1:0] RECIP_VOLT_HI = RECIP_W'(RECIP_ONE / 64'(DIV_VOLT_HI));
	localparam logic [RECIP_W-1:0] RECIP_CUR_1   = RECIP_W'(RECIP_ONE / 64'(DIV_CUR_1));
	localparam logic [RECIP_W-1:0] RECIP_CUR_2   = RECIP_W'(RECIP_ONE / 64'(DIV_CUR_2));
	localparam logic [RECIP_W-1:0] RECIP_CUR_3   = RECIP_W'(RECIP_ONE / 64'(DIV_CUR_3));
	localparam logic [RECIP_W-1:0] RECIP_CUR_4   = RECIP_W'(RECIP_ONE / 64'(DIV_CUR_4));
	localparam logic [RECIP_W-1:0] RECIP_CUR_5   = RECIP_W'(RECIP_ONE / 64'(DIV_CUR_5));
	localparam logic [RECIP_W-1:0] RECIP_POW_LO  = RECIP_W'(RECIP_ONE / 64'(DIV_POW_LO));
	localparam logic [RECIP_W-1:0] RECIP_POW_HI  = RECIP_W'(RECIP_ONE / 64'(DIV_POW_HI));

	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [READING_W-1:0] reading;
	} sample_t;

	typedef struct packed {
		logic [AVG_W-1:0]  average;
		logic [MODE_W-1:0] quantity;
	} result_t;

	typedef struct packed {
		logic [X_W-1:0]     x;
		logic [DIV_W-1:0]   divisor;
		logic [RECIP_W-1:0] recip;
		logic               add_offset;
	} band_t;

endpackage

FILE: sv/mrsa_band.sv
// ----------------------------------------------------------------------------
// mrsa_band: scaling band select
// Picks dividend, divisor, reciprocal and offset for one reading.
// ----------------------------------------------------------------------------
module mrsa_band (
	input  logic [mrsa_pkg::MODE_W-1:0]    mode,
	input  logic [mrsa_pkg::READING_W-1:0] reading,
	output mrsa_pkg::band_t                band
);

	logic [mrsa_pkg::X_W-1:0] power;
	logic [mrsa_pkg::X_W-1:0] volt_x;

	// 24-bit negate, zero reading gives 2^24
	assign power  = {1'b0, ~reading} + mrsa_pkg::X_W'(1);
	assign volt_x = mrsa_pkg::X_W'(reading);

	always_comb begin
		band.x          = volt_x;
		band.divisor    = mrsa_pkg::DIV_VOLT_LO;
		band.recip      = mrsa_pkg::RECIP_VOLT_LO;
		band.add_offset = 1'b0;
		case (mode)
			mrsa_pkg::MODE_VOLTAGE: begin
				if (reading >= mrsa_pkg::VOLT_KNEE) begin
					band.divisor = mrsa_pkg::DIV_VOLT_HI;
					band.recip   = mrsa_pkg::RECIP_VOLT_HI;
				end
			end
			mrsa_pkg::MODE_CURRENT: begin
				if (reading < mrsa_pkg::CUR_KNEE1) begin
					band.divisor = mrsa_pkg::DIV_CUR_1;
					band.recip   = mrsa_pkg::RECIP_CUR_1;
				end else if (reading <= mrsa_pkg::CUR_KNEE2) begin
					band.divisor = mrsa_pkg::DIV_CUR_2;
					band.recip   = mrsa_pkg::RECIP_CUR_2;
				end else if (reading <= mrsa_pkg::CUR_KNEE3) begin
					band.divisor = mrsa_pkg::DIV_CUR_3;
					band.recip   = mrsa_pkg::RECIP_CUR_3;
				end else if (reading <= mrsa_pkg::CUR_KNEE4) begin
					band.divisor = mrsa_pkg::DIV_CUR_4;
					band.recip   = mrsa_pkg::RECIP_CUR_4;
				end else begin
					band.divisor = mrsa_pkg::DIV_CUR_5;
					band.recip   = mrsa_pkg::RECIP_CUR_5;
				end
			end
			mrsa_pkg::MODE_POWER: begin
				if (power < mrsa_pkg::POWER_KNEE) begin
					band.x       = power;
					band.divisor = mrsa_pkg::DIV_POW_LO;
					band.recip   = mrsa_pkg::RECIP_POW_LO;
				end else begin
					band.x          = power - mrsa_pkg::POWER_KNEE;
					band.divisor    = mrsa_pkg::DIV_POW_HI;
					band.recip      = mrsa_pkg::RECIP_POW_HI;
					band.add_offset = 1'b1;
				end
			end
			default: begin
				// unused mode is dropped before this point
				band.x = volt_x;
			end
		endcase
	end

endmodule

FILE: sv/meter_reading_scale_average.sv
// ----------------------------------------------------------------------------
// meter_reading_scale_average: meter reading scaler and batch averager
// Scales tagged 24-bit meter readings and emits the mean of each batch.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel (sample_valid / sample_stall / sample) carries one word per
//   meter reading: mode (0 voltage, 1 current, 2 active power) and the raw
//   24-bit reading. A word with mode 3 is taken and discarded.
//   result channel (result_valid / result_stall / result) carries one word per
//   completed batch of SAMPLES readings: the truncated mean of the scaled
//   readings and the mode of the reading that closed the batch.
// Throughput: one sample word per cycle, sustained unless a held result backs up the stages.
// Path: a batch-closing reading passes the input register, quotient estimate
//   multiply, back-multiply, correction plus accumulate and mean multiply
//   before the registered result word shows.
// Stall: each stage holds only while the stage after it is full and held.
//   Stage four keeps only batch-closing words, so behind a held result the
//   readings keep flowing until the next batch closes into stage four; three
//   more words then fill stages one to three and sample_stall rises.
// Reset: arst_n clears all stage valids, the running sum and the count; the
//   first batch starts at the first word after reset.
// ----------------------------------------------------------------------------
module meter_reading_scale_average #(
	parameter int SAMPLES = mrsa_pkg::DEFAULT_SAMPLES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  mrsa_pkg::sample_t sample,
	output logic              result_valid,
	input  logic              result_stall,
	output mrsa_pkg::result_t result
);

	localparam int SUM_W     = $clog2(SAMPLES * mrsa_pkg::SCALED_MAX + 1);
	localparam int CNT_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int AVG_SHIFT = SUM_W + 2 * $clog2(SAMPLES);
	localparam int AVG_RECIP_W = AVG_SHIFT - $clog2(SAMPLES) + 2;
	localparam int AVG_PROD_W = SUM_W + AVG_RECIP_W;
	localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES - 1);
	// ceil(2^AVG_SHIFT / SAMPLES): rounding error times any sum stays below
	// 2^AVG_SHIFT / SAMPLES, so the truncated quotient is exact
	localparam logic [63:0] AVG_RECIP_FULL =
		((64'd1 << AVG_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
	localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_FULL[AVG_RECIP_W-1:0];

	localparam int PROD1_W = mrsa_pkg::X_W + mrsa_pkg::RECIP_W;
	localparam int PROD2_W = mrsa_pkg::SCALED_W + mrsa_pkg::DIV_W;

	// ---------------- stage handshake ----------------
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_out;
	logic result_valid_q;

	assign rdy_out = !result_valid_q || !result_stall;
	assign rdy_s4  = !valid_s4 || rdy_out;
	assign rdy_s3  = !valid_s3 || rdy_s4;
	assign rdy_s2  = !valid_s2 || rdy_s3;
	assign rdy_s1  = !valid_s1 || rdy_s2;

	assign sample_stall = !rdy_s1;
	assign result_valid = result_valid_q;

	// ---------------- stage 1: input register ----------------
	logic [mrsa_pkg::MODE_W-1:0]    mode_s1;
	logic [mrsa_pkg::READING_W-1:0] reading_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= sample_valid && (sample.mode != mrsa_pkg::MODE_UNUSED);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			mode_s1    <= sample.mode;
			reading_s1 <= sample.reading;
		end
	end

	// band select and quotient estimate x * floor(2^25/d) >> 25
	mrsa_pkg::band_t      band_s1;
	logic [PROD1_W-1:0]   est_prod;

	mrsa_band u_band (
		.mode    (mode_s1),
		.reading (reading_s1),
		.band    (band_s1)
	);

	assign est_prod = PROD1_W'(band_s1.x) * PROD1_W'(band_s1.recip);

	// ---------------- stage 2: estimate ----------------
	logic [mrsa_pkg::SCALED_W-1:0] qe_s2;
	logic [mrsa_pkg::X_W-1:0]      x_s2;
	logic [mrsa_pkg::DIV_W-1:0]    div_s2;
	logic                          off_s2;
	logic [mrsa_pkg::MODE_W-1:0]   mode_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			qe_s2   <= est_prod[mrsa_pkg::RECIP_SHIFT +: mrsa_pkg::SCALED_W];
			x_s2    <= band_s1.x;
			div_s2  <= band_s1.divisor;
			off_s2  <= band_s1.add_offset;
			mode_s2 <= mode_s1;
		end
	end

	// back-multiply; q*d never exceeds x, so it fits the dividend width
	logic [PROD2_W-1:0] back_prod;

	assign back_prod = PROD2_W'(qe_s2) * PROD2_W'(div_s2);

	// ---------------- stage 3: correct and accumulate ----------------
	logic [mrsa_pkg::SCALED_W-1:0] qe_s3;
	logic [mrsa_pkg::X_W-1:0]      x_s3;
	logic [mrsa_pkg::X_W-1:0]      prod_s3;
	logic [mrsa_pkg::DIV_W-1:0]    div_s3;
	logic                          off_s3;
	logic [mrsa_pkg::MODE_W-1:0]   mode_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			qe_s3   <= qe_s2;
			x_s3    <= x_s2;
			prod_s3 <= back_prod[mrsa_pkg::X_W-1:0];
			div_s3  <= div_s2;
			off_s3  <= off_s2;
			mode_s3 <= mode_s2;
		end
	end

	logic [mrsa_pkg::X_W-1:0]      rem_s3;
	logic                          corr_s3;
	logic [mrsa_pkg::SCALED_W-1:0] scaled_s3;
	logic [SUM_W-1:0]              sum_q;
	logic [CNT_W-1:0]              count_q;
	logic [SUM_W-1:0]              total_s3;
	logic                          fire_s3;
	logic                          last_s3;

	assign rem_s3    = x_s3 - prod_s3;
	assign corr_s3   = rem_s3 >= mrsa_pkg::X_W'(div_s3);
	assign scaled_s3 = qe_s3 + mrsa_pkg::SCALED_W'(corr_s3)
		+ (off_s3 ? mrsa_pkg::POWER_OFFSET : '0);
	assign total_s3  = sum_q + SUM_W'(scaled_s3);
	assign fire_s3   = valid_s3 && rdy_s4;
	assign last_s3   = count_q == LAST_COUNT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (fire_s3) begin
			if (last_s3) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= total_s3;
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// ---------------- stage 4: batch total ----------------
	logic [SUM_W-1:0]            total_s4;
	logic [mrsa_pkg::MODE_W-1:0] mode_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (rdy_s4) begin
			valid_s4 <= fire_s3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			total_s4 <= total_s3;
			mode_s4  <= mode_s3;
		end
	end

	// mean by exact reciprocal multiply
	logic [AVG_PROD_W-1:0] avg_prod;

	assign avg_prod = AVG_PROD_W'(total_s4) * AVG_PROD_W'(AVG_RECIP);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (rdy_out) begin
			result_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			result.average  <= avg_prod[AVG_SHIFT +: mrsa_pkg::AVG_W];
			result.quantity <= mode_s4;
		end
	end

`ifndef SYNTH
	// batch count stays below SAMPLES
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LAST_COUNT)
		else $error("batch count out of range");

	// quotient estimate is never more than one low
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> ((mrsa_pkg::X_W + 1)'(rem_s3) < ((mrsa_pkg::X_W + 1)'(div_s3) << 1)))
		else $error("quotient estimate off by more than one");

	// scaled value stays inside its range
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (scaled_s3 <= mrsa_pkg::SCALED_W'(mrsa_pkg::SCALED_MAX)))
		else $error("scaled value out of range");

	// closing a batch loads a total and clears the accumulator
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s3 && last_s3) |=> (valid_s4 && sum_q == '0 && count_q == '0))
		else $error("batch close did not hand over");

	// input backs up only behind a held result
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (result_valid_q && result_stall))
		else $error("input stalled without output back-pressure");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for meter_reading_scale_average
// Drives tagged meter readings (directed band edges, then biased random
// words) under four idle/stall phases and compares each batch mean against
// an in-bench scaler and averager.
// ----------------------------------------------------------------------------
module testbench;
	import mrsa_pkg::*;

	localparam int BATCH_LEN    = DEFAULT_SAMPLES;
	localparam int RANDOM_WORDS = 1750;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE       = 16;      // wait after the last drain, before the summary
	localparam int PLAN_LEN     = 25;

	// power readings are negated before scaling, so the knee sits near the top
	localparam logic [READING_W-1:0] POWER_KNEE_RAW = 24'd16771216;  // p = 6000

	localparam result_t NO_MEAN = '0;

	typedef struct packed {
		sample_t word;
		logic    typed;    // expected mean written in by hand
		result_t mean;
	} plan_row_t;

	// Directed words. First batch: ten power readings of zero (negated to the
	// largest value, so the mean is the scaled maximum) with an unused-mode
	// word wedged in, which must neither count nor change the sum. Second
	// batch: most band edges, modes mixed, closed by a power word. The tail
	// holds the rest and starts a third batch that the random part finishes.
	plan_row_t directed_plan [PLAN_LEN] = '{
		'{'{MODE_POWER,   24'd0},        1'b0, NO_MEAN},
		'{'{MODE_POWER,   24'd0},        1'b0, NO_MEAN},
		'{'{MODE_POWER,   24'd0},        1'b0, NO_MEAN},
		'{'{MODE_POWER,   24'd0},        1'b0, NO_MEAN},
		'{'{MODE_UNUSED,  24'hFFFFFF},   1'b0, NO_MEAN},
		'{'{MODE_POWER,   24'd0},        1'b0, NO_MEAN},
		'{'{MODE_POWER,   24'd0},        1'b0, NO_MEAN},
		'{'{MODE_POWER,   24'd0},        1'b0, NO_MEAN},
		'{'{MODE_POWER,   24'd0},        1'b0, NO_MEAN},
		'{'{MODE_POWER,   24'd0},        1'b0, NO_MEAN},
		'{'{MODE_POWER,   24'd0},        1'b1, '{19'(SCALED_MAX), MODE_POWER}},
		'{'{MODE_VOLTAGE, 24'd0},        1'b0, NO_MEAN},
		'{'{MODE_VOLTAGE, 24'd5999999},  1'b0, NO_MEAN},
		'{'{MODE_VOLTAGE, 24'd6000000},  1'b0, NO_MEAN},
		'{'{MODE_VOLTAGE, 24'hFFFFFF},   1'b0, NO_MEAN},
		'{'{MODE_CURRENT, 24'd269999},   1'b0, NO_MEAN},
		'{'{MODE_CURRENT, 24'd270000},   1'b0, NO_MEAN},
		'{'{MODE_CURRENT, 24'd290001},   1'b0, NO_MEAN},
		'{'{MODE_CURRENT, 24'd330001},   1'b0, NO_MEAN},
		'{'{MODE_CURRENT, 24'd360001},   1'b0, NO_MEAN},
		'{'{MODE_POWER,   24'hFFFFFF},   1'b0, NO_MEAN},
		'{'{MODE_CURRENT, 24'd290000},   1'b0, NO_MEAN},
		'{'{MODE_CURRENT, 24'd330000},   1'b0, NO_MEAN},
		'{'{MODE_CURRENT, 24'd360000},   1'b0, NO_MEAN},
		'{'{MODE_POWER,   POWER_KNEE_RAW}, 1'b0, NO_MEAN}
	};

	logic    clk;
	logic    arst_n       = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_stall;
	sample_t sample       = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// bench-side copy of the batch state
	longint unsigned batch_sum  = 0;
	int              batch_fill = 0;
	result_t         expected_means [$];

	int idle_pct  = 0;
	int stall_pct = 0;
	int cycle_count   = 0;
	int mismatches    = 0;
	int words_sent    = 0;
	int words_ignored = 0;
	int means_checked = 0;
	result_t want;

	meter_reading_scale_average #(.SAMPLES(BATCH_LEN)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d means still owed",
				cycle_count, expected_means.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint exp_val);
		$display("mismatch @%0d: %s got %0d, expected %0d", cycle_count, what, got, exp_val);
		mismatches++;
	endtask

	// Piecewise scaling, all products at 64 bits so nothing wraps.
	function automatic longint unsigned scaled_reading(input sample_t w);
		longint unsigned r;
		longint unsigned p;
		r = w.reading;
		case (w.mode)
			MODE_VOLTAGE: begin
				if (r < VOLT_KNEE) return r * 150 / 6000000;
				return r * 200 / 7600000;
			end
			MODE_CURRENT: begin
				if (r < CUR_KNEE1)  return r * 100 / 300000;
				if (r <= CUR_KNEE2) return r * 200 / 300000;
				if (r <= CUR_KNEE3) return r * 300 / 330000;
				if (r <= CUR_KNEE4) return r * 400 / 380000;
				return r * 500 / 430000;
			end
			default: begin
				// two's complement negate in 24 bits; zero maps to 2^24
				p = ((~r) & 64'hFFFFFF) + 1;
				if (p < 6000) return p * 100 / 47000;
				return (p - 6000) * 1000 / 60000 + 30;
			end
		endcase
	endfunction

	// Fold one taken word into the batch; closes is set when a mean is due.
	task automatic accumulate_reading(input sample_t w, output bit closes, output result_t mean);
		closes = 1'b0;
		mean   = '0;
		if (w.mode == MODE_UNUSED) begin
			words_ignored++;
			return;
		end
		batch_sum += scaled_reading(w);
		batch_fill++;
		if (batch_fill >= BATCH_LEN) begin
			mean.average  = AVG_W'(batch_sum / BATCH_LEN);
			mean.quantity = w.mode;
			closes        = 1'b1;
			batch_sum     = 0;
			batch_fill    = 0;
		end
	endtask

	// Present one word, hold it until taken, then maybe go idle for a while.
	task automatic send_word(input sample_t w, input logic typed, input result_t typed_mean);
		bit      closes;
		result_t mean;
		int      gap;
		sample       <= w;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		words_sent++;
		accumulate_reading(w, closes, mean);
		if (typed) mean = typed_mean;
		if (closes) expected_means.push_back(mean);
		gap = 0;
		while (gap < 200 && $urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and hold off until every owed mean has come back.
	task automatic drain_means();
		sample_valid <= 1'b0;
		do @(posedge clk); while (expected_means.size() != 0);
	endtask

	// Random readings lean on band edges and the extremes.
	function automatic logic [READING_W-1:0] pick_reading(input logic [MODE_W-1:0] mode);
		int knee;
		case ($urandom_range(9))
			0, 1, 2, 3: return READING_W'($urandom);
			8:          return $urandom_range(1) ? 24'hFFFFFF : 24'd0;
			9:          return READING_W'($urandom_range(7000));
			default: begin
				case (mode)
					MODE_VOLTAGE: knee = int'(VOLT_KNEE);
					MODE_CURRENT: begin
						case ($urandom_range(3))
							0:       knee = int'(CUR_KNEE1);
							1:       knee = int'(CUR_KNEE2);
							2:       knee = int'(CUR_KNEE3);
							default: knee = int'(CUR_KNEE4);
						endcase
					end
					default: knee = int'(POWER_KNEE_RAW);
				endcase
				return READING_W'(knee + int'($urandom_range(6)) - 3);
			end
		endcase
	endfunction

	// Result side: check each taken word, then register a new random stall.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			means_checked <= means_checked + 1;
			if (expected_means.size() == 0) begin
				report_mismatch("result word with no batch owed", result.average, -1);
			end else begin
				want = expected_means.pop_front();
				if (result.average !== want.average)
					report_mismatch("average", result.average, want.average);
				if (result.quantity !== want.quantity)
					report_mismatch("quantity", result.quantity, want.quantity);
			end
		end
		result_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	initial begin
		int      phase_idle  [4];
		int      phase_stall [4];
		int      counted;
		sample_t w;
		phase_idle  = '{0, 86, 0, 18};
		phase_stall = '{0, 0, 86, 18};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at full rate
		for (int i = 0; i < PLAN_LEN; i++)
			send_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].mean);
		drain_means();

		// random words, one chunk per idle/stall phase, drained in between
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = phase_idle[ph];
			stall_pct = phase_stall[ph];
			counted   = 0;
			while (counted < RANDOM_WORDS / 4) begin
				if ($urandom_range(15) == 0) w.mode = MODE_UNUSED;
				else                         w.mode = MODE_W'($urandom_range(2));
				w.reading = pick_reading(w.mode);
				send_word(w, 1'b0, NO_MEAN);
				if (w.mode != MODE_UNUSED) counted++;
			end
			drain_means();
		end

		repeat (SETTLE) @(posedge clk);
		$display("took %0d reading words (%0d with the unused mode), checked %0d batch means",
			words_sent, words_ignored, means_checked);
		$display("across no-idle, sender-idle, receiver-stall and mixed phases; %0d mismatches",
			mismatches);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/mrsa_pkg.sv
sv/mrsa_band.sv
sv/meter_reading_scale_average.sv
bench/testbench.sv
